/* sv/iis_pkg.sv */
// Package for the integral image stream block.
// Widths, register indexes, result type and saturation helpers.
// No dependencies.
package iis_pkg;

   localparam int PIX_W     = 8;
   localparam int ROW_W     = 19;
   localparam int SUM_W     = 29;
   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 2;
   // wide enough for any column or row limit up to 4096
   localparam int EXT_W     = 16;
   localparam int RSPQ_DEPTH = 3;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FOVEA_ROWS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIGNED     = 2'd3;

   localparam logic [CSR_W-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [CSR_W-1:0] HEIGHT_RESET = 11'd1024;

   typedef struct packed {
      logic                    frame_end;
      logic signed [SUM_W-1:0] area_sum;
   } rsp_item_type;

   function automatic logic signed [ROW_W-1:0] sat_row(input logic signed [ROW_W:0] v);
      logic signed [ROW_W-1:0] r;
      if (v[ROW_W] != v[ROW_W-1]) begin
         r = v[ROW_W] ? {1'b1, {(ROW_W-1){1'b0}}} : {1'b0, {(ROW_W-1){1'b1}}};
      end else begin
         r = v[ROW_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
      logic signed [SUM_W-1:0] r;
      if (v[SUM_W] != v[SUM_W-1]) begin
         r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         r = v[SUM_W-1:0];
      end
      return r;
   endfunction

endpackage

/* sv/integral_image_stream.sv */
// Streaming integral image (summed-area table) over 8-bit raster pixels.
// Top level; depends on iis_pkg, iis_ram and iis_rsp_queue.
//
// Usage:
//   req channel: one pixel per transaction, raster order, req_valid/req_ready.
//   rsp channel: one area_sum per pixel, in order; rsp_frame_end marks the
//   last pixel of the frame.
//   csr port: csr_write_en, csr_index (0 width, 1 height, 2 fovea_rows,
//   3 signed_pixels), csr_data. Write only while no transaction is in flight.
// Throughput: one pixel per clock while req_ready is high. The line store
// is read when a pixel is taken and written back in the following cycle;
// a pixel that hits the column just written gets the new value forwarded.
// A result passes through one compute stage, then the result queue, before
// it is offered on rsp.
// Stall: a three-entry result queue keeps the input side running; req_ready
// drops only once the queue plus the pixel in flight fill it.
// Reset: registers return to width 1024, height 1024, no fovea, unsigned.
// Counters clear; the line store reads as zero until each column has been
// written (a fill mark tracks the written columns, no clearing pass).
module integral_image_stream
   import iis_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [PIX_W-1:0]        req_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [SUM_W-1:0] rsp_area_sum,
   output logic                    rsp_frame_end,
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   // configuration
   logic [CSR_W-1:0] width_ff, height_ff, fovea_ff;
   logic             signed_ff;

   // position counters and line-store fill mark
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [CW:0]      fill_ff, fill_in;

   // accept stage
   logic                    accept;
   logic [EXT_W-1:0]        w_eff, h_eff;
   logic [EXT_W-1:0]        col_ext, row_ext, col_c, row_c, col_nxt, row_nxt;
   logic [CW-1:0]           a_col;
   logic                    a_last_col, a_last_row, a_fovea, a_fwd, a_top;
   logic signed [PIX_W:0]   a_pix;

   // compute stage
   logic                    b_valid_ff;
   logic [CW-1:0]           b_col_ff;
   logic signed [PIX_W:0]   b_pix_ff;
   logic                    b_zero_ff, b_top_ff, b_first_ff, b_last_col_ff, b_end_ff;
   logic                    b_fwd_ff;
   logic signed [SUM_W-1:0] b_fwd_sum_ff;
   logic signed [ROW_W-1:0] acc_ff, acc_in, b_acc;
   logic signed [SUM_W-1:0] b_above, b_sum, ram_rd;
   logic [SUM_W-1:0]        ram_rd_raw;

   rsp_item_type            b_item, q_item;
   logic [1:0]              q_count;

   assign accept = req_valid && req_ready;
   assign req_ready = ({1'b0, q_count} + {2'b00, b_valid_ff}) < 3'(RSPQ_DEPTH);

   // effective limits: zero means one, above the maximum saturates
   always_comb begin
      if (width_ff == '0) begin
         w_eff = EXT_W'(1);
      end else if (EXT_W'(width_ff) > EXT_W'(MAX_WIDTH)) begin
         w_eff = EXT_W'(MAX_WIDTH);
      end else begin
         w_eff = EXT_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = EXT_W'(1);
      end else if (EXT_W'(height_ff) > EXT_W'(MAX_HEIGHT)) begin
         h_eff = EXT_W'(MAX_HEIGHT);
      end else begin
         h_eff = EXT_W'(height_ff);
      end
   end

   always_comb begin
      col_ext    = EXT_W'(col_ff);
      row_ext    = EXT_W'(row_ff);
      col_c      = (col_ext >= w_eff) ? w_eff - EXT_W'(1) : col_ext;
      row_c      = (row_ext >= h_eff) ? h_eff - EXT_W'(1) : row_ext;
      col_nxt    = col_c + EXT_W'(1);
      row_nxt    = row_c + EXT_W'(1);
      a_col      = col_c[CW-1:0];
      a_last_col = (col_nxt >= w_eff);
      a_last_row = (row_nxt >= h_eff);
      a_fovea    = (row_c < EXT_W'(fovea_ff));
      // the pixel in the compute stage writes this column at the coming edge
      a_fwd      = b_valid_ff && (b_col_ff == a_col);
      a_top      = (row_c == '0) || (!(EXT_W'(fill_ff) > col_c) && !a_fwd);
      if (signed_ff) begin
         a_pix = {req_pixel[PIX_W-1], req_pixel};
      end else begin
         a_pix = {1'b0, req_pixel};
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      fill_in = fill_ff;
      if (accept) begin
         if (a_last_col) begin
            col_in = '0;
            row_in = a_last_row ? '0 : row_nxt[RW-1:0];
         end else begin
            col_in = col_nxt[CW-1:0];
            row_in = row_c[RW-1:0];
         end
      end
      if (b_valid_ff && ({1'b0, b_col_ff} >= fill_ff)) begin
         fill_in = {1'b0, b_col_ff} + (CW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         fovea_ff   <= '0;
         signed_ff  <= 1'b0;
         col_ff     <= '0;
         row_ff     <= '0;
         fill_ff    <= '0;
         acc_ff     <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_WIDTH:      width_ff  <= csr_data;
               REG_HEIGHT:     height_ff <= csr_data;
               REG_FOVEA_ROWS: fovea_ff  <= csr_data;
               REG_SIGNED:     signed_ff <= csr_data[0];
               default: ;
            endcase
         end
         col_ff     <= col_in;
         row_ff     <= row_in;
         fill_ff    <= fill_in;
         acc_ff     <= acc_in;
         b_valid_ff <= accept;
      end
   end

   // compute-stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         b_col_ff      <= a_col;
         b_pix_ff      <= a_pix;
         b_zero_ff     <= a_fovea;
         b_top_ff      <= a_top;
         b_first_ff    <= (a_col == '0);
         b_last_col_ff <= a_last_col;
         b_end_ff      <= a_last_col && a_last_row;
         b_fwd_ff      <= a_fwd;
         b_fwd_sum_ff  <= b_sum;
      end
   end

   iis_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_col_ff),
      .wr_data (b_sum),
      .rd_en   (accept),
      .rd_addr (a_col),
      .rd_data (ram_rd_raw)
   );

   assign ram_rd = ram_rd_raw;

   always_comb begin
      if (b_top_ff) begin
         b_above = '0;
      end else if (b_fwd_ff) begin
         b_above = b_fwd_sum_ff;
      end else begin
         b_above = ram_rd;
      end
      if (b_first_ff) begin
         b_acc = ROW_W'(b_pix_ff);
      end else begin
         b_acc = sat_row((ROW_W+1)'(acc_ff) + (ROW_W+1)'(b_pix_ff));
      end
      if (b_zero_ff) begin
         b_acc = '0;
         b_sum = '0;
      end else begin
         b_sum = sat_sum((SUM_W+1)'(b_above) + (SUM_W+1)'(b_acc));
      end
      acc_in = acc_ff;
      if (b_valid_ff) begin
         acc_in = b_last_col_ff ? '0 : b_acc;
      end
      b_item.frame_end = b_end_ff;
      b_item.area_sum  = b_sum;
   end

   iis_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (b_valid_ff),
      .push_item (b_item),
      .count     (q_count),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (q_item)
   );

   assign rsp_area_sum  = q_item.area_sum;
   assign rsp_frame_end = q_item.frame_end;

endmodule

/* sv/iis_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read during a write to the same address returns the old contents.
// No dependencies.
module iis_ram #(
   parameter int WIDTH = 29,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/iis_rsp_queue.sv */
// Small result queue in front of the rsp channel.
// Absorbs results while the receiver stalls; exposes its fill count.
// Depends on iis_pkg.
module iis_rsp_queue
   import iis_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic [1:0]   count,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   rsp_item_type entry_ff [RSPQ_DEPTH];
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_item  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == 2'(RSPQ_DEPTH - 1)) ? 2'd0 : wr_ptr_ff + 2'd1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == 2'(RSPQ_DEPTH - 1)) ? 2'd0 : rd_ptr_ff + 2'd1;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
